>>> rtl/core/mvnl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvnl_pkg
// Shared constants and types of the motion vector normalize/limit block.
// ----------------------------------------------------------------------------
package mvnl_pkg;

  localparam int AXES       = 3;   // axes that take part (1..3)
  localparam int LANES      = 3;   // axes that carry data
  localparam int DW         = 32;  // delta / register width
  localparam int ROOT_W     = 32;  // floor sqrt of a 64 bit sum
  localparam int SUM_W      = 64;
  localparam int UNIT_W     = 31;  // magnitude of a Q1.30 unit component
  localparam int LIMIT_W    = 40;
  localparam int LEN_W      = 33;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DW-1:0] AXIS_MAX_RESET = 32'd524288000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_MAX_X = 2'd0,
    REG_AXIS_MAX_Y = 2'd1,
    REG_AXIS_MAX_Z = 2'd2
  } cfg_reg_t;

  // per-item data that rides along the square-root pipeline
  typedef struct packed {
    logic [LANES-1:0][DW-1:0] mag;
    logic [LANES-1:0]         neg;
  } mvnl_side_t;

endpackage

>>> rtl/core/mvnl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvnl_req_if / mvnl_rsp_if
// Valid/ready channels for segment requests and normalized results.
// ----------------------------------------------------------------------------
interface mvnl_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] delta_x;
  logic signed [31:0] delta_y;
  logic signed [31:0] delta_z;

  modport source (output valid, delta_x, delta_y, delta_z, input ready);
  modport sink   (input valid, delta_x, delta_y, delta_z, output ready);
endinterface

interface mvnl_rsp_if;
  logic               valid;
  logic               ready;
  logic        [32:0] length;
  logic signed [31:0] unit_x;
  logic signed [31:0] unit_y;
  logic signed [31:0] unit_z;
  logic        [39:0] axis_limited;
  logic               zero_vector;

  modport source (output valid, length, unit_x, unit_y, unit_z, axis_limited,
                  zero_vector, input ready);
  modport sink   (input valid, length, unit_x, unit_y, unit_z, axis_limited,
                  zero_vector, output ready);
endinterface

>>> rtl/core/mvnl_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvnl_sqrt
// Pipelined integer square root, one result bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module mvnl_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [63:0]          in_sum,
  input  mvnl_pkg::mvnl_side_t in_side,
  output logic                 out_valid,
  output logic [31:0]          out_root,
  output mvnl_pkg::mvnl_side_t out_side
);
  import mvnl_pkg::*;

  localparam int STEPS = ROOT_W;

  logic              valid [0:STEPS];
  logic [SUM_W-1:0]  sum   [0:STEPS];
  logic [ROOT_W-1:0] rem   [0:STEPS];
  logic [ROOT_W-1:0] root  [0:STEPS];
  mvnl_side_t        side  [0:STEPS];

  assign valid[0] = in_valid;
  assign sum[0]   = in_sum;
  assign rem[0]   = '0;
  assign root[0]  = '0;
  assign side[0]  = in_side;

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [ROOT_W+1:0] r2;
    logic [ROOT_W+1:0] trial;
    logic              take;

    always_comb begin
      r2    = {rem[j], sum[j][SUM_W-1-2*j -: 2]};
      trial = {root[j], 2'b01};
      take  = (r2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j+1] <= 1'b0;
      end else if (en) begin
        valid[j+1] <= valid[j];
      end
      if (en) begin
        sum[j+1]  <= sum[j];
        side[j+1] <= side[j];
        rem[j+1]  <= take ? ROOT_W'(r2 - trial) : r2[ROOT_W-1:0];
        root[j+1] <= {root[j][ROOT_W-2:0], take};
      end
    end
  end

  assign out_valid = valid[STEPS];
  assign out_root  = root[STEPS];
  assign out_side  = side[STEPS];

  a_valid_follows: assert property (@(posedge clk) disable iff (rst)
    en |=> valid[1] == $past(in_valid)) else $error("sqrt valid lost");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_root) && $stable(out_valid))
    else $error("sqrt moved while stalled");
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_root == 32'd0) == (out_side.mag == '0))
    else $error("root zero mismatch");
endmodule

>>> rtl/core/motion_vector_normalize_limit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_vector_normalize_limit_top
// Segment length, unit direction and per-axis limited value.
// ----------------------------------------------------------------------------
// Accepts one segment per cycle unless a result waits; the stages are the
// input register, squares, sum, a 32-stage square root, a 31-stage restoring
// divider for the unit components and a 40-stage restoring divider for the
// axis limit (all three axes in parallel lanes), then the output register.
// The whole pipeline advances together; it halts only while a result waits.
// ----------------------------------------------------------------------------
module motion_vector_normalize_limit_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [mvnl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  mvnl_req_if.sink                      req,
  mvnl_rsp_if.source                    rsp
);
  import mvnl_pkg::*;

  localparam int UD = UNIT_W;   // unit divider steps
  localparam int LD = LIMIT_W;  // limit divider steps

  function automatic logic [DW:0] div_step(input logic [DW-1:0] r,
                                           input logic nbit,
                                           input logic [DW-1:0] dvs);
    logic [DW:0] t;
    begin
      t = {r, nbit};
      if (t >= {1'b0, dvs}) return {1'b1, DW'(t - {1'b0, dvs})};
      return {1'b0, t[DW-1:0]};
    end
  endfunction

  logic en;
  logic [DW-1:0] axis_max [LANES];

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LANES; k++) axis_max[k] <= AXIS_MAX_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_AXIS_MAX_X: axis_max[0] <= cfg_data;
        REG_AXIS_MAX_Y: axis_max[1] <= cfg_data;
        REG_AXIS_MAX_Z: axis_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: magnitude and sign
  logic              a_valid;
  mvnl_side_t        a_side;
  logic [DW-1:0]     d_in [LANES];

  assign d_in[0] = req.delta_x;
  assign d_in[1] = req.delta_y;
  assign d_in[2] = req.delta_z;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= req.valid;
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        if (k < AXES) begin
          a_side.neg[k] <= d_in[k][DW-1];
          a_side.mag[k] <= d_in[k][DW-1] ? DW'(-d_in[k]) : d_in[k];
        end else begin
          a_side.neg[k] <= 1'b0;
          a_side.mag[k] <= '0;
        end
      end
    end
  end

  // squares, then sum
  logic             b_valid, c_valid;
  mvnl_side_t       b_side, c_side;
  logic [SUM_W-1:0] b_sq [LANES];
  logic [SUM_W-1:0] c_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
    if (en) begin
      for (int k = 0; k < LANES; k++) b_sq[k] <= a_side.mag[k] * a_side.mag[k];
      b_side <= a_side;
      c_sum  <= b_sq[0] + b_sq[1] + b_sq[2];
      c_side <= b_side;
    end
  end

  logic        s_valid;
  logic [31:0] s_root;
  mvnl_side_t  s_side;

  mvnl_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c_valid), .in_sum(c_sum), .in_side(c_side),
    .out_valid(s_valid), .out_root(s_root), .out_side(s_side)
  );

  // unit divider: (mag << 30) / len, quotient below 2^31
  logic              ud_valid [0:UD];
  logic [DW-1:0]     ud_len   [0:UD];
  mvnl_side_t        ud_side  [0:UD];
  logic [DW-1:0]     ud_rem   [0:UD][LANES];
  logic [UNIT_W-1:0] ud_q     [0:UD][LANES];

  assign ud_valid[0] = s_valid;
  assign ud_len[0]   = s_root;
  assign ud_side[0]  = s_side;
  for (genvar k = 0; k < LANES; k++) begin : g_ud0
    assign ud_rem[0][k] = {1'b0, s_side.mag[k][DW-1:1]};
    assign ud_q[0][k]   = '0;
  end

  for (genvar j = 0; j < UD; j++) begin : g_ud
    always_ff @(posedge clk) begin
      if (rst) ud_valid[j+1] <= 1'b0;
      else if (en) ud_valid[j+1] <= ud_valid[j];
      if (en) begin
        ud_len[j+1]  <= ud_len[j];
        ud_side[j+1] <= ud_side[j];
        for (int k = 0; k < LANES; k++) begin
          logic [DW:0] st;
          st = div_step(ud_rem[j][k], (j == 0) ? ud_side[j].mag[k][0] : 1'b0,
                        ud_len[j]);
          ud_rem[j+1][k] <= st[DW-1:0];
          ud_q[j+1][k]   <= {ud_q[j][k][UNIT_W-2:0], st[DW]};
        end
      end
    end
  end

  // limit divider: (amax << 30) / unit, saturating above 2^40-1
  logic              ld_valid [0:LD];
  logic [DW-1:0]     ld_len   [0:LD];
  logic [LANES-1:0]  ld_neg   [0:LD];
  logic [UNIT_W-1:0] ld_u     [0:LD][LANES];
  logic              ld_sat   [0:LD][LANES];
  logic [DW-1:0]     ld_rem   [0:LD][LANES];
  logic [LIMIT_W-1:0] ld_q    [0:LD][LANES];

  assign ld_valid[0] = ud_valid[UD];
  assign ld_len[0]   = ud_len[UD];
  assign ld_neg[0]   = ud_side[UD].neg;
  for (genvar k = 0; k < LANES; k++) begin : g_ld0
    assign ld_u[0][k]   = (ud_len[UD] == '0) ? '0 : ud_q[UD][k];
    assign ld_sat[0][k] = {9'd0, axis_max[k]} >= {ld_u[0][k], 10'd0};
    assign ld_rem[0][k] = {10'd0, axis_max[k][DW-1:10]};
    assign ld_q[0][k]   = '0;
  end

  for (genvar j = 0; j < LD; j++) begin : g_ld
    localparam int BIT = LD - 1 - j;  // dividend bit brought in
    always_ff @(posedge clk) begin
      if (rst) ld_valid[j+1] <= 1'b0;
      else if (en) ld_valid[j+1] <= ld_valid[j];
      if (en) begin
        ld_len[j+1] <= ld_len[j];
        ld_neg[j+1] <= ld_neg[j];
        for (int k = 0; k < LANES; k++) begin
          logic [DW:0] st;
          logic        nb;
          nb = (BIT >= 30) ? axis_max[k][(BIT >= 30) ? BIT - 30 : 0] : 1'b0;
          st = div_step(ld_rem[j][k], nb, {1'b0, ld_u[j][k]});
          ld_u[j+1][k]   <= ld_u[j][k];
          ld_sat[j+1][k] <= ld_sat[j][k];
          ld_rem[j+1][k] <= st[DW-1:0];
          ld_q[j+1][k]   <= {ld_q[j][k][LIMIT_W-2:0], st[DW]};
        end
      end
    end
  end

  // minimum over usable axes, then output register
  logic [LIMIT_W-1:0] cand [LANES];
  logic [LIMIT_W-1:0] lim;

  always_comb begin
    lim = '1;
    for (int k = 0; k < LANES; k++) begin
      cand[k] = ld_sat[LD][k] ? '1 : ld_q[LD][k];
      if (ld_u[LD][k] != '0 && cand[k] < lim) lim = cand[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rsp.valid <= 1'b0;
    else if (en) rsp.valid <= ld_valid[LD];
    if (en) begin
      rsp.length       <= {1'b0, ld_len[LD]};
      rsp.unit_x       <= ld_neg[LD][0] ? -{1'b0, ld_u[LD][0]} : {1'b0, ld_u[LD][0]};
      rsp.unit_y       <= ld_neg[LD][1] ? -{1'b0, ld_u[LD][1]} : {1'b0, ld_u[LD][1]};
      rsp.unit_z       <= ld_neg[LD][2] ? -{1'b0, ld_u[LD][2]} : {1'b0, ld_u[LD][2]};
      rsp.axis_limited <= lim;
      rsp.zero_vector  <= (ld_len[LD] == '0);
    end
  end

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.zero_vector == (rsp.length == '0))
    else $error("zero_vector does not match length");
  a_zero_limit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.zero_vector |-> rsp.axis_limited == '1 &&
      rsp.unit_x == '0 && rsp.unit_y == '0 && rsp.unit_z == '0)
    else $error("zero vector result not clean");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(ld_valid[LD]) && $stable(ud_valid[UD]))
    else $error("pipeline moved while stalled");
endmodule
